@@ src/ppurp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppurp_pkg
// Shared types and constants of the video unit's CPU register port.
// ----------------------------------------------------------------------------
`default_nettype none

package ppurp_pkg;

  // Memory address widths
  localparam int OAM_AW = 8;   // 256 bytes of OAM
  localparam int NT_AW  = 11;  // two 1 KiB nametable banks
  localparam int PAL_AW = 5;   // 32 palette bytes
  localparam int PAT_AW = 13;  // 8 KiB pattern store
  localparam int BUS_AW = 14;  // video bus address

  // Operation codes
  localparam logic [2:0] OP_REG_READ  = 3'd0;
  localparam logic [2:0] OP_REG_WRITE = 3'd1;
  localparam logic [2:0] OP_OAM_DMA   = 3'd2;
  localparam logic [2:0] OP_VBL_ENTER = 3'd3;
  localparam logic [2:0] OP_VBL_EXIT  = 3'd4;

  // Port register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Mirroring modes
  localparam logic [1:0] MIR_HORZ = 2'd0;
  localparam logic [1:0] MIR_VERT = 2'd1;
  localparam logic [1:0] MIR_LOW  = 2'd2;
  localparam logic [1:0] MIR_HIGH = 2'd3;

  // Palette page starts at 0x3F00 on the bus
  localparam logic [5:0] PAL_PAGE = 6'h3F;

  // One accepted request
  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] register_index;
    logic [7:0] oam_index;
    logic [7:0] data_byte;
  } req_t;

  // Post-reset clearing sweep, shared by all memories
  typedef struct packed {
    logic              active;
    logic [PAT_AW-1:0] index;
  } clr_t;

endpackage

`default_nettype wire

@@ src/ppu_register_port.sv @@
// ----------------------------------------------------------------------------
// ppu_register_port
// CPU-facing register port of a tile video unit: control, scroll/address
// registers, OAM and the video bus memories.
// ----------------------------------------------------------------------------
// After reset the block sweeps all memories to zero and takes no request
// while the sweep runs (mirror_mode writes are taken). The result of a
// request is loaded into the output register from the run state that follows
// acceptance, and from the read state after it for OAM data and data port
// reads, which wait on the synchronous memory read before the read buffer and
// address are updated. The next request is accepted once the port is back in
// idle, which it enters as the result is loaded. A full output register holds
// the request that follows until the result is taken.
// One request is in flight at a time; the result sits in an output register,
// so the next request is accepted while it waits to be taken.
`default_nettype none

module ppu_register_port (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,    // mirror_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [7:0] oam_index, [15:8] data_byte
  input  wire logic [5:0]  in_tuser,     // [2:0] operation, [5:3] register_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata     // [7:0] read_data, [8] nmi_request,
                                         // [24:9] current_address, rest zero
);
  import ppurp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]  state_r, state_nxt;
  req_t        req_r, req_nxt;
  logic [1:0]  mirror_r;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic        vbl_r, vbl_nxt;
  logic        toggle_r, toggle_nxt;
  logic [15:0] t_r, t_nxt;
  logic [15:0] v_r, v_nxt;
  logic [7:0]  buf_r, buf_nxt;
  logic [7:0]  oam_ptr_r, oam_ptr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  clr_t        clr;
  logic        accept, out_free, go_read, fin_run, fin_read;
  logic [15:0] v_step;
  logic [7:0]  rd;
  logic        nmi;
  logic        vm_we, oam_we;
  logic [7:0]  vm_rdata, oam_rdata;
  logic [OAM_AW-1:0] oam_waddr;

  assign accept    = in_tvalid & in_tready;
  assign in_tready = (state_r == S_IDLE) & ~clr.active;
  assign out_free  = ~out_valid_r | out_tready;
  assign go_read   = (state_r == S_RUN) & (req_r.operation == OP_REG_READ) &
                     ((req_r.register_index == REG_OAM_DATA) ||
                      (req_r.register_index == REG_DATA));
  assign fin_run   = (state_r == S_RUN) & ~go_read & out_free;
  assign fin_read  = (state_r == S_READ) & out_free;
  assign v_step    = v_r + (ctrl_r[2] ? 16'd32 : 16'd1);

  // memory writes commit only when the request finishes
  assign vm_we     = fin_run & (req_r.operation == OP_REG_WRITE) &
                     (req_r.register_index == REG_DATA);
  assign oam_we    = fin_run & (((req_r.operation == OP_REG_WRITE) &
                     (req_r.register_index == REG_OAM_DATA)) |
                     (req_r.operation == OP_OAM_DMA));
  assign oam_waddr = (req_r.operation == OP_OAM_DMA) ? req_r.oam_index : oam_ptr_r;

  ppurp_vmem u_vmem (
    .clk         (clk),
    .rst_n       (rst_n),
    .mirror_mode (mirror_r),
    .wr_en       (vm_we),
    .rd_en       (go_read),
    .addr        (v_r[BUS_AW-1:0]),
    .wr_data     (req_r.data_byte),
    .rd_data     (vm_rdata),
    .clr         (clr)
  );

  ppurp_oam u_oam (
    .clk     (clk),
    .clr     (clr),
    .wr_en   (oam_we),
    .wr_addr (oam_waddr),
    .wr_data (req_r.data_byte),
    .rd_en   (go_read),
    .rd_addr (oam_ptr_r),
    .rd_data (oam_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    ctrl_nxt      = ctrl_r;
    vbl_nxt       = vbl_r;
    toggle_nxt    = toggle_r;
    t_nxt         = t_r;
    v_nxt         = v_r;
    buf_nxt       = buf_r;
    oam_ptr_nxt   = oam_ptr_r;
    rd            = 8'h00;
    nmi           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = {in_tuser[2:0], in_tuser[5:3], in_tdata[7:0], in_tdata[15:8]};
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (go_read) begin
          state_nxt = S_READ;
        end else if (out_free) begin
          state_nxt = S_IDLE;
          case (req_r.operation)
            OP_REG_READ: begin
              if (req_r.register_index == REG_STATUS) begin
                rd         = {vbl_r, 2'b00, buf_r[4:0]};
                vbl_nxt    = 1'b0;
                toggle_nxt = 1'b0;
              end else begin
                rd = buf_r;
              end
            end
            OP_REG_WRITE: begin
              case (req_r.register_index)
                REG_CTRL: begin
                  ctrl_nxt       = req_r.data_byte;
                  t_nxt[11:10]   = req_r.data_byte[1:0];
                end
                REG_STATUS:   buf_nxt     = req_r.data_byte;
                REG_OAM_ADDR: oam_ptr_nxt = req_r.data_byte;
                REG_OAM_DATA: begin
                  if (!vbl_r) begin
                    oam_ptr_nxt = oam_ptr_r + 8'd1;
                  end
                end
                REG_SCROLL: begin
                  if (toggle_r) begin
                    t_nxt[9:5]   = req_r.data_byte[7:3];
                    t_nxt[14:12] = req_r.data_byte[2:0];
                  end else begin
                    t_nxt[4:0]   = req_r.data_byte[7:3];
                  end
                  toggle_nxt = ~toggle_r;
                end
                REG_ADDR: begin
                  if (toggle_r) begin
                    t_nxt[7:0] = req_r.data_byte;
                    v_nxt      = {t_r[15:8], req_r.data_byte};
                  end else begin
                    t_nxt[15:8] = {2'b00, req_r.data_byte[5:0]};
                  end
                  toggle_nxt = ~toggle_r;
                end
                REG_DATA: v_nxt = v_step;
                default: ;  // mask register: no effect here
              endcase
            end
            OP_VBL_ENTER: begin
              vbl_nxt = 1'b1;
              nmi     = ctrl_r[7];
            end
            OP_VBL_EXIT: vbl_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (req_r.register_index == REG_OAM_DATA) begin
            rd = oam_rdata;
          end else begin
            buf_nxt = vm_rdata;
            // palette page returns the fresh byte
            rd      = (v_r[BUS_AW-1:8] == PAL_PAGE) ? vm_rdata : buf_r;
            v_nxt   = v_step;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (fin_run || fin_read) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'b0, v_nxt, nmi, rd};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mirror_r    <= MIR_HORZ;
      ctrl_r      <= 8'h00;
      vbl_r       <= 1'b0;
      toggle_r    <= 1'b0;
      t_r         <= 16'h0000;
      v_r         <= 16'h0000;
      buf_r       <= 8'h00;
      oam_ptr_r   <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        mirror_r <= cfg_wdata;
      end
      ctrl_r      <= ctrl_nxt;
      vbl_r       <= vbl_nxt;
      toggle_r    <= toggle_nxt;
      t_r         <= t_nxt;
      v_r         <= v_nxt;
      buf_r       <= buf_nxt;
      oam_ptr_r   <= oam_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr.active |-> !in_tready)
    else $error("request accepted during memory clear");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RUN))
    else $error("accepted request did not start");

  a_read_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ($past(state_r) == S_RUN || $past(state_r) == S_READ))
    else $error("memory read stage entered without an issued read");

  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_run && req_r.operation == OP_REG_READ &&
     req_r.register_index == REG_STATUS) |=> (!vbl_r && !toggle_r))
    else $error("status read did not clear vblank and toggle");

  a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_run || fin_read) |=> out_tvalid)
    else $error("finished request produced no result");
`endif

endmodule

`default_nettype wire

@@ src/ppurp_oam.sv @@
// ----------------------------------------------------------------------------
// ppurp_oam
// 256-byte object attribute memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppurp_oam (
  input  wire logic                           clk,
  input  wire ppurp_pkg::clr_t                clr,
  input  wire logic                           wr_en,
  input  wire logic [ppurp_pkg::OAM_AW-1:0]   wr_addr,
  input  wire logic [7:0]                     wr_data,
  input  wire logic                           rd_en,
  input  wire logic [ppurp_pkg::OAM_AW-1:0]   rd_addr,
  output logic      [7:0]                     rd_data
);
  import ppurp_pkg::*;

  logic [7:0]        mem [0:(1<<OAM_AW)-1];
  logic              we;
  logic [OAM_AW-1:0] waddr;
  logic [7:0]        wdata;

  // zero the array during the sweep
  assign we    = clr.active | wr_en;
  assign waddr = clr.active ? clr.index[OAM_AW-1:0] : wr_addr;
  assign wdata = clr.active ? 8'h00 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/ppurp_vmem.sv @@
// ----------------------------------------------------------------------------
// ppurp_vmem
// Video bus memories: pattern store, mirrored nametables and folded palette,
// with the post-reset clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module ppurp_vmem (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [1:0]                     mirror_mode,
  input  wire logic                           wr_en,
  input  wire logic                           rd_en,
  input  wire logic [ppurp_pkg::BUS_AW-1:0]   addr,
  input  wire logic [7:0]                     wr_data,
  output logic      [7:0]                     rd_data,
  output ppurp_pkg::clr_t                     clr
);
  import ppurp_pkg::*;

  logic [7:0] pat_mem [0:(1<<PAT_AW)-1];
  logic [7:0] nt_mem  [0:(1<<NT_AW)-1];
  logic [7:0] pal_mem [0:(1<<PAL_AW)-1];

  logic              clr_busy_r, clr_busy_nxt;
  logic [PAT_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              is_pat, is_pal, is_nt;
  logic              nt_bank;
  logic [NT_AW-1:0]  nt_slot;
  logic [PAL_AW-1:0] pal_slot;

  logic              pat_we, nt_we, pal_we;
  logic [PAT_AW-1:0] pat_wa;
  logic [NT_AW-1:0]  nt_wa;
  logic [PAL_AW-1:0] pal_wa;
  logic [7:0]        wd;

  logic [7:0]        pat_q, nt_q, pal_q;
  logic              sel_pat_r, sel_pal_r;

  // sweep every pattern address once after reset; the smaller memories take the low index bits
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == {PAT_AW{1'b1}}) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  assign clr.active = clr_busy_r;
  assign clr.index  = clr_cnt_r;

  // address decode
  assign is_pat = ~addr[BUS_AW-1];
  assign is_pal = (addr[BUS_AW-1:8] == PAL_PAGE);
  assign is_nt  = ~is_pat & ~is_pal;

  always_comb begin
    case (mirror_mode)
      MIR_HORZ: nt_bank = addr[11];
      MIR_VERT: nt_bank = addr[10];
      MIR_LOW:  nt_bank = 1'b0;
      MIR_HIGH: nt_bank = 1'b1;
      default:  nt_bank = 1'b0;
    endcase
  end

  assign nt_slot  = {nt_bank, addr[NT_AW-2:0]};
  // backdrop entries 0x10/0x14/0x18/0x1C fold onto 0x00/0x04/0x08/0x0C
  assign pal_slot = {addr[4] & (addr[1:0] != 2'b00), addr[3:0]};

  assign wd     = clr_busy_r ? 8'h00 : wr_data;
  assign pat_we = clr_busy_r | (wr_en & is_pat);
  assign nt_we  = clr_busy_r | (wr_en & is_nt);
  assign pal_we = clr_busy_r | (wr_en & is_pal);
  assign pat_wa = clr_busy_r ? clr_cnt_r : addr[PAT_AW-1:0];
  assign nt_wa  = clr_busy_r ? clr_cnt_r[NT_AW-1:0] : nt_slot;
  assign pal_wa = clr_busy_r ? clr_cnt_r[PAL_AW-1:0] : pal_slot;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_wa] <= wd;
    end
    if (rd_en) begin
      pat_q <= pat_mem[addr[PAT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_mem[nt_wa] <= wd;
    end
    if (rd_en) begin
      nt_q <= nt_mem[nt_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_wa] <= wd;
    end
    if (rd_en) begin
      pal_q <= pal_mem[pal_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sel_pat_r <= is_pat;
      sel_pal_r <= is_pal;
    end
  end

  assign rd_data = sel_pat_r ? pat_q : (sel_pal_r ? pal_q : nt_q);

endmodule

`default_nettype wire
